// ----- src/i2a_pkg.sv -----
// Package for the integer-to-decimal-text converter.
// Holds the item type passed from the front end to the back end and shared constants.
// No dependencies.
package i2a_pkg;

  // Decimal digits of a 32-bit magnitude
  localparam int DIGITS = 10;
  localparam int DIG_W  = 4;
  localparam int CNT_W  = 4;

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  // floor(x / 10) = (x * RECIP_10) >> RECIP_SHIFT, exact for any 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // One converted number: sign, digit count, digits with the leading one at index 0
  typedef struct packed {
    logic                         neg;
    logic [CNT_W-1:0]             ndig;
    logic [DIGITS-1:0][DIG_W-1:0] digits;
  } item_t;

endpackage

// ----- src/int32_to_decimal_ascii_top.sv -----
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Instantiates i2a_front, i2a_fifo and i2a_back; uses i2a_pkg.
//
//  Port group | Dir | Payload
//  -----------+-----+--------------------------------------------------
//  in_*       | in  | tdata[31:0] = value (signed)
//  out_*      | out | tdata[6:0] = character, tdata[7] = 0; tlast = last
//
// The splitter accepts a number, then does one reciprocal multiply per digit; the
// output sends the sign, if any, then one character per cycle while out_tready
// allows it. The splitter has a single digit multiplier and the output a single
// character register; a new number is split while the previous one is sent.
// Reset is synchronous, active low, and clears all control state; no clearing pass.
// Output stalls back up through the queue; the splitter keeps working until it is full.
module int32_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] character, [7] zero
  output logic        out_tlast
);
  import i2a_pkg::*;

  logic       push_valid, push_ready;
  item_t      push_item;
  logic       pop_valid, pop_ready;
  item_t      pop_item;
  logic [6:0] char_w;

  i2a_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_value   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  i2a_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_item)
  );

  i2a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_w),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, char_w};

endmodule

// ----- src/i2a_front.sv -----
// Front end: accepts a signed value and splits its magnitude into decimal digits.
// One digit per cycle through a reciprocal multiply. Depends on i2a_pkg.
module i2a_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    in_value,
  output logic           push_valid,
  input  logic           push_ready,
  output i2a_pkg::item_t push_item
);
  import i2a_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic                         neg_r, neg_nxt;
  logic [31:0]                  mag_r, mag_nxt;
  logic [CNT_W-1:0]             ndig_r, ndig_nxt;
  logic [DIGITS-1:0][DIG_W-1:0] digits_r, digits_nxt;

  logic [63:0]                  prod;
  logic [31:0]                  quot;
  logic [DIG_W-1:0]             dig;
  logic [CNT_W-1:0]             ndig_inc;
  logic [DIGITS-1:0][DIG_W-1:0] digits_sh;
  logic                         fin;

  // Quotient and remainder by ten; remainder needs only the low four bits
  assign prod      = {32'd0, mag_r} * {32'd0, RECIP_10};
  assign quot      = {{(RECIP_SHIFT - 32){1'b0}}, prod[63:RECIP_SHIFT]};
  assign dig       = mag_r[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
  assign ndig_inc  = ndig_r + 1'b1;
  assign digits_sh = {digits_r[DIGITS-2:0], dig};
  assign fin       = (quot == 32'd0) || (ndig_r == CNT_W'(DIGITS - 1));

  assign in_ready   = (state_r == ST_IDLE);
  assign push_valid = (state_r == ST_HOLD) || ((state_r == ST_CONV) && fin);

  // Finished item goes straight out on the last digit, or from the hold registers
  always_comb begin
    push_item.neg = neg_r;
    if (state_r == ST_HOLD) begin
      push_item.ndig   = ndig_r;
      push_item.digits = digits_r;
    end else begin
      push_item.ndig   = ndig_inc;
      push_item.digits = digits_sh;
    end
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    ndig_nxt   = ndig_r;
    digits_nxt = digits_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_value[31];
          mag_nxt   = in_value[31] ? (32'd0 - in_value) : in_value;
          ndig_nxt  = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        mag_nxt    = quot;
        ndig_nxt   = ndig_inc;
        digits_nxt = digits_sh;
        if (fin) begin
          state_nxt = push_ready ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    ndig_r   <= ndig_nxt;
    digits_r <= digits_nxt;
  end

endmodule

// ----- src/i2a_fifo.sv -----
// Small queue between the digit splitter and the character emitter.
// Show-ahead read, register storage. Depends on i2a_pkg.
module i2a_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  i2a_pkg::item_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output i2a_pkg::item_t rd_data
);
  import i2a_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/i2a_back.sv -----
// Back end: emits sign and digits of a queued number, one character per cycle while out_ready allows it.
// Registered output stage. Depends on i2a_pkg.
module i2a_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  i2a_pkg::item_t pop_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           out_last
);
  import i2a_pkg::*;

  logic                         active_r;
  logic                         sign_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [DIGITS-1:0][DIG_W-1:0] digits_r;
  logic                         out_valid_r;
  logic [6:0]                   out_char_r;
  logic                         out_last_r;

  logic adv, done_now;

  assign adv       = !out_valid_r || out_ready;
  assign done_now  = active_r && !sign_r && (cnt_r == CNT_W'(1));
  assign pop_ready = !active_r || (adv && done_now);

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // Sequencer over the current number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        out_valid_r <= active_r;
      end
      if (pop_valid && pop_ready) begin
        active_r <= 1'b1;
      end else if (adv && done_now) begin
        active_r <= 1'b0;
      end
    end
  end

  // Character register
  always_ff @(posedge clk) begin
    if (adv && active_r) begin
      if (sign_r) begin
        out_char_r <= CHAR_MINUS;
        out_last_r <= 1'b0;
      end else begin
        out_char_r <= CHAR_ZERO + {3'b000, digits_r[0]};
        out_last_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  // Per-number registers: load a new number, or step past the character just sent
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      sign_r   <= pop_item.neg;
      cnt_r    <= pop_item.ndig;
      digits_r <= pop_item.digits;
    end else if (adv && active_r) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else begin
        digits_r <= {{DIG_W{1'b0}}, digits_r[DIGITS-1:1]};
        cnt_r    <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- src/i2a_checker.sv -----
// Port-level checks for the decimal text converter.
// Bound to int32_to_decimal_ascii_top; no package dependency.
module i2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Output register empties on reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Only a minus sign or a decimal digit appears
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata == 8'd45) ||
                    ((out_tdata >= 8'd48) && (out_tdata <= 8'd57))))
    else $error("character outside sign and digits");

  // A sign is never marked last: digits of the same number follow it
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata == 8'd45)) |-> !out_tlast)
    else $error("minus sign marked last");

  // After a sign transfer, the next character is a leading digit, never '0' or '-'
  a_no_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && (out_tdata == 8'd45)) |=>
      (!out_tvalid || ((out_tdata != 8'd48) && (out_tdata != 8'd45))))
    else $error("bad character after minus sign");

  // Stalled output holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("output changed while stalled");

endmodule

bind int32_to_decimal_ascii_top i2a_checker u_i2a_checker (.*);
